>>> sv/lcdnf_pkg.sv
`default_nettype none

package lcdnf_pkg;

    // Request operation codes.
    localparam logic [3:0] OP_CMD      = 4'd0;
    localparam logic [3:0] OP_CHAR     = 4'd1;
    localparam logic [3:0] OP_MOVE     = 4'd2;
    localparam logic [3:0] OP_DEC      = 4'd3;
    localparam logic [3:0] OP_HEX      = 4'd4;
    localparam logic [3:0] OP_CLRLINE  = 4'd5;
    localparam logic [3:0] OP_CLEAR    = 4'd6;
    localparam logic [3:0] OP_INIT     = 4'd7;
    localparam logic [3:0] OP_SHUTDOWN = 4'd8;

    // Wait classes after a strobe.
    typedef logic [2:0] t_wait;
    localparam t_wait W_50US  = 3'd0;
    localparam t_wait W_2MS   = 3'd1;
    localparam t_wait W_50MS  = 3'd2;
    localparam t_wait W_5MS   = 3'd3;
    localparam t_wait W_200US = 3'd4;

    // Expander byte bits.
    localparam logic [7:0] BIT_RS = 8'h01;
    localparam logic [7:0] BIT_EN = 8'h04;
    localparam logic [7:0] BIT_BL = 8'h08;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rem_en;
        logic dig_en;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic none;
        logic last;
    } t_dp_sts;

    // Width of the strobe counter for a given line length.
    function automatic int strobe_cnt_w(input int cols);
        int n;
        n = 2 * cols + 2;
        if (n < 15) begin
            n = 15;
        end
        return $clog2(n + 1);
    endfunction

endpackage

`default_nettype wire

>>> sv/lcdnf_req_if.sv
`default_nettype none

interface lcdnf_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] op;
    logic [7:0] value;
    logic       row;
    logic [5:0] col;
    logic [7:0] blank_cols;

    modport source (output valid, output op, output value, output row, output col,
                    output blank_cols, input ready);
    modport sink   (input valid, input op, input value, input row, input col,
                    input blank_cols, output ready);
endinterface

`default_nettype wire

>>> sv/lcdnf_strobe_if.sv
`default_nettype none

interface lcdnf_strobe_if;
    logic       valid;
    logic       ready;
    logic [7:0] strobe_high_byte;
    logic [7:0] strobe_low_byte;
    logic [2:0] wait_after;
    logic       last;

    modport source (output valid, output strobe_high_byte, output strobe_low_byte,
                    output wait_after, output last, input ready);
    modport sink   (input valid, input strobe_high_byte, input strobe_low_byte,
                    input wait_after, input last, output ready);
endinterface

`default_nettype wire

>>> sv/lcdnf_ctrl.sv
`default_nettype none

module lcdnf_ctrl #(
    parameter int LINE_COLUMNS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    input  lcdnf_pkg::t_dp_sts  i_sts,
    output lcdnf_pkg::t_dp_cmd  o_cmd,
    output logic [lcdnf_pkg::strobe_cnt_w(LINE_COLUMNS)-1:0] o_idx
);

    localparam int CW = lcdnf_pkg::strobe_cnt_w(LINE_COLUMNS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_REM  = 2'd1;
    localparam logic [1:0] S_DIG  = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_REM;
                end
            end
            S_REM: begin
                o_cmd.rem_en = 1'b1;
                n_state      = S_DIG;
            end
            S_DIG: begin
                o_cmd.dig_en = 1'b1;
                n_state      = S_SEND;
            end
            S_SEND: begin
                if (i_sts.none) begin
                    n_state = S_IDLE;
                end else begin
                    o_out_valid = 1'b1;
                    if (i_out_ready) begin
                        if (i_sts.last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx + CW'(1);
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

`default_nettype wire

>>> sv/lcdnf_dp.sv
`default_nettype none

module lcdnf_dp #(
    parameter int LINE_COLUMNS = 16
) (
    input  wire                 i_clk,
    input  lcdnf_pkg::t_dp_cmd  i_cmd,
    input  wire [lcdnf_pkg::strobe_cnt_w(LINE_COLUMNS)-1:0] i_idx,
    input  wire [3:0]           i_op,
    input  wire [7:0]           i_value,
    input  wire                 i_row,
    input  wire [5:0]           i_col,
    input  wire [7:0]           i_blank_cols,
    output lcdnf_pkg::t_dp_sts  o_sts,
    output logic [7:0]          o_high,
    output logic [7:0]          o_low,
    output lcdnf_pkg::t_wait    o_wait
);

    localparam int CW = lcdnf_pkg::strobe_cnt_w(LINE_COLUMNS);
    localparam int MW = $clog2(LINE_COLUMNS + 1);

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        return (d < 4'd10) ? (8'h30 + {4'b0, d}) : (8'h37 + {4'b0, d});
    endfunction

    logic [3:0]    r_op;
    logic [7:0]    r_value;
    logic          r_row;
    logic [5:0]    r_col;
    logic [MW-1:0] r_m;
    logic [1:0]    r_hund;
    logic [6:0]    r_rem;
    logic [3:0]    r_tens;
    logic [1:0]    r_skip;
    logic [CW-1:0] r_cnt;

    // Hundreds digit by reciprocal multiply, exact for all 8-bit values.
    logic [13:0] hund_prod;
    logic [14:0] tens_prod;
    logic [3:0]  n_tens;
    logic [1:0]  n_skip;
    logic [CW-1:0] n_cnt;

    assign hund_prod = 14'(i_value) * 14'd41;
    assign tens_prod = 15'(r_rem) * 15'd205;
    assign n_tens    = tens_prod[14:11];

    always_comb begin
        n_skip = 2'd0;
        n_cnt  = '0;
        if (r_op == lcdnf_pkg::OP_DEC) begin
            n_skip = (r_hund != 2'd0) ? 2'd0 : ((n_tens != 4'd0) ? 2'd1 : 2'd2);
        end else if (r_op == lcdnf_pkg::OP_HEX) begin
            n_skip = (r_value[7:4] == 4'd0) ? 2'd1 : 2'd0;
        end
        unique case (r_op) inside
            lcdnf_pkg::OP_CMD, lcdnf_pkg::OP_CHAR, lcdnf_pkg::OP_MOVE,
            lcdnf_pkg::OP_CLEAR:   n_cnt = CW'(2);
            lcdnf_pkg::OP_DEC,
            lcdnf_pkg::OP_HEX:     n_cnt = CW'({2'd3 - n_skip, 1'b0});
            lcdnf_pkg::OP_CLRLINE: n_cnt = CW'({r_m, 1'b0}) + CW'(2);
            lcdnf_pkg::OP_INIT:    n_cnt = CW'(15);
            lcdnf_pkg::OP_SHUTDOWN: n_cnt = CW'(4);
            default:               n_cnt = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value;
            r_row   <= i_row;
            r_col   <= i_col;
            r_m     <= (i_blank_cols > 8'(LINE_COLUMNS)) ? MW'(LINE_COLUMNS)
                                                         : i_blank_cols[MW-1:0];
            r_hund  <= hund_prod[13:12];
        end
        if (i_cmd.rem_en) begin
            r_rem <= 7'(r_value - ({6'b0, r_hund} * 8'd100));
        end
        if (i_cmd.dig_en) begin
            r_tens <= n_tens;
            r_skip <= n_skip;
            r_cnt  <= n_cnt;
        end
    end

    // Strobe content for the current index.
    logic [CW-1:0] e;
    logic [CW-2:0] j;
    logic          ph;
    logic [1:0]    pos;
    logic [6:0]    ones_full;
    logic [3:0]    digit;
    logic [7:0]    byte_v;
    logic          rs;
    lcdnf_pkg::t_wait wait_lo;
    logic          ovr;
    logic [3:0]    ovr_nib;
    lcdnf_pkg::t_wait ovr_wait;
    logic [3:0]    nib;
    logic [7:0]    base;

    assign ones_full = r_rem - ({3'b0, r_tens} * 7'd10);

    always_comb begin
        e        = (r_op == lcdnf_pkg::OP_INIT) ? (i_idx - CW'(5)) : i_idx;
        j        = e[CW-1:1];
        ph       = e[0];
        pos      = 2'd0;
        digit    = 4'd0;
        byte_v   = r_value;
        rs       = 1'b0;
        wait_lo  = lcdnf_pkg::W_50US;
        ovr      = 1'b0;
        ovr_nib  = 4'd0;
        ovr_wait = lcdnf_pkg::W_50US;
        unique case (r_op)
            lcdnf_pkg::OP_CMD: begin
                byte_v = r_value;
            end
            lcdnf_pkg::OP_CHAR: begin
                byte_v = r_value;
                rs     = 1'b1;
            end
            lcdnf_pkg::OP_MOVE: begin
                byte_v = {1'b1, r_row, 6'b0} + {2'b0, r_col};
            end
            lcdnf_pkg::OP_DEC: begin
                pos = 2'(j) + r_skip;
                if (pos == 2'd0) begin
                    digit = {2'b0, r_hund};
                end else if (pos == 2'd1) begin
                    digit = r_tens;
                end else begin
                    digit = ones_full[3:0];
                end
                byte_v = 8'h30 | {4'b0, digit};
                rs     = 1'b1;
            end
            lcdnf_pkg::OP_HEX: begin
                pos = (j == '0) ? 2'd0 : (2'(j) + r_skip);
                if (pos == 2'd0) begin
                    byte_v = 8'h78;
                end else if (pos == 2'd1) begin
                    byte_v = hex_char(r_value[7:4]);
                end else begin
                    byte_v = hex_char(r_value[3:0]);
                end
                rs = 1'b1;
            end
            lcdnf_pkg::OP_CLRLINE: begin
                if (j == '0) begin
                    byte_v = {1'b1, r_row, 6'b0};
                end else begin
                    byte_v = 8'h20;
                    rs     = 1'b1;
                end
            end
            lcdnf_pkg::OP_CLEAR: begin
                byte_v  = 8'h01;
                wait_lo = lcdnf_pkg::W_2MS;
            end
            lcdnf_pkg::OP_INIT: begin
                if (i_idx < CW'(5)) begin
                    ovr = 1'b1;
                    case (i_idx[2:0]) inside
                        3'd0: begin
                            ovr_nib  = 4'h0;
                            ovr_wait = lcdnf_pkg::W_50MS;
                        end
                        3'd1: begin
                            ovr_nib  = 4'h3;
                            ovr_wait = lcdnf_pkg::W_5MS;
                        end
                        3'd2, 3'd3: begin
                            ovr_nib  = 4'h3;
                            ovr_wait = lcdnf_pkg::W_200US;
                        end
                        default: begin
                            ovr_nib  = 4'h2;
                            ovr_wait = lcdnf_pkg::W_50US;
                        end
                    endcase
                end
                if (j == (CW-1)'(0)) begin
                    byte_v = 8'h28;
                end else if (j == (CW-1)'(1)) begin
                    byte_v = 8'h08;
                end else if (j == (CW-1)'(2)) begin
                    byte_v  = 8'h01;
                    wait_lo = lcdnf_pkg::W_2MS;
                end else if (j == (CW-1)'(3)) begin
                    byte_v = 8'h06;
                end else begin
                    byte_v = 8'h0C;
                end
            end
            lcdnf_pkg::OP_SHUTDOWN: begin
                if (j == '0) begin
                    byte_v  = 8'h01;
                    wait_lo = lcdnf_pkg::W_2MS;
                end else begin
                    byte_v = 8'h08;
                end
            end
            default: begin
                byte_v = r_value;
            end
        endcase

        nib    = ovr ? ovr_nib : (ph ? byte_v[3:0] : byte_v[7:4]);
        o_wait = ovr ? ovr_wait : (ph ? wait_lo : lcdnf_pkg::W_50US);
        base   = {nib, 4'b0} | lcdnf_pkg::BIT_BL | (rs ? lcdnf_pkg::BIT_RS : 8'h00);
        o_high = base | lcdnf_pkg::BIT_EN;
        o_low  = base;
    end

    assign o_sts.none = (r_cnt == '0);
    assign o_sts.last = (i_idx == (r_cnt - CW'(1)));

endmodule

`default_nettype wire

>>> sv/char_lcd_nibble_framer_top.sv
`default_nettype none

// A request is taken in the idle state; the remainder and digit states then prepare
// the decimal digits before the first strobe beat is offered, and strobes follow one
// per cycle while the receiver is ready. A request of N strobes (N up to the larger of
// 15 and 2*LINE_COLUMNS+2) is finished before the next one is taken; stalls lengthen it.
// Reset: synchronous, active low; the controller returns to idle with no beat pending.
module char_lcd_nibble_framer_top #(
    parameter int LINE_COLUMNS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    lcdnf_req_if.sink    i_req,
    lcdnf_strobe_if.source o_strobe
);

    localparam int CW = lcdnf_pkg::strobe_cnt_w(LINE_COLUMNS);

    // The controller owns the handshakes and the strobe counter; the datapath
    // holds the request, prepares decimal digits and decodes each strobe.
    lcdnf_pkg::t_dp_cmd cmd;
    lcdnf_pkg::t_dp_sts sts;
    logic [CW-1:0]      idx;
    logic               in_ready;
    logic               out_valid;

    lcdnf_ctrl #(
        .LINE_COLUMNS (LINE_COLUMNS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_strobe.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_idx       (idx)
    );

    lcdnf_dp #(
        .LINE_COLUMNS (LINE_COLUMNS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_idx        (idx),
        .i_op         (i_req.op),
        .i_value      (i_req.value),
        .i_row        (i_req.row),
        .i_col        (i_req.col),
        .i_blank_cols (i_req.blank_cols),
        .o_sts        (sts),
        .o_high       (o_strobe.strobe_high_byte),
        .o_low        (o_strobe.strobe_low_byte),
        .o_wait       (o_strobe.wait_after)
    );

    // The final strobe of a request is flagged from the counter compare.
    assign i_req.ready    = in_ready;
    assign o_strobe.valid = out_valid;
    assign o_strobe.last  = sts.last;

endmodule

`default_nettype wire

>>> sv/lcdnf_checker.sv
`default_nettype none

module lcdnf_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       i_in_ready,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_high,
    input wire [7:0] i_low,
    input wire [2:0] i_wait,
    input wire       i_last
);

    // A request is never taken while a strobe is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request taken while a strobe is pending");

    // Strobes never appear in the cycle after a request is taken.
    a_prep_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_out_valid)
        else $error("strobe offered without preparation");

    // The final strobe of a request closes it.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last) |=> (!i_out_valid && i_in_ready))
        else $error("strobe after the final one of a request");

    // Strobe bytes agree: enable only in the high byte, backlight on, write mode.
    a_byte_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_high[2] && i_high[3] && !i_high[1]
                         && (i_low == (i_high & 8'hFB))))
        else $error("inconsistent strobe byte pair");

    a_wait_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_wait <= 3'd4))
        else $error("wait class out of range");

endmodule

bind char_lcd_nibble_framer_top lcdnf_checker u_lcdnf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_strobe.valid),
    .i_out_ready (o_strobe.ready),
    .i_high      (o_strobe.strobe_high_byte),
    .i_low       (o_strobe.strobe_low_byte),
    .i_wait      (o_strobe.wait_after),
    .i_last      (o_strobe.last)
);

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int LINE_COLUMNS   = 16;
    localparam int CYCLE_LIMIT    = 400000;
    // Quiet cycles after the last strobe: well beyond the set-up the block needs
    // for a request, so a stray beat would still be caught.
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_PHASE_A = 120;
    localparam int RANDOM_PHASE_B = 120;
    localparam int RANDOM_PHASE_C = 117;
    localparam int N_DIRECTED     = 23;

    // Display command bytes and the characters the framer emits on its own.
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_ENTRY_INC    = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_FUNC_4BIT_2L = 8'h28;
    localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
    localparam logic [7:0] ROW1_BASE        = 8'h40;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] CHAR_ZERO        = 8'h30;
    localparam logic [7:0] CHAR_A           = 8'h41;
    localparam logic [7:0] CHAR_X           = 8'h78;
    localparam logic [3:0] OP_UNUSED_LO     = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI     = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
        logic [7:0] blank_cols;
    } t_lcd_request;

    typedef struct packed {
        logic [7:0]       high_byte;
        logic [7:0]       low_byte;
        lcdnf_pkg::t_wait wait_after;
        logic             last;
    } t_lcd_strobe;

    // One row of the directed table. A typed count of -1 hands the row to the
    // predictor; otherwise the listed strobes are the whole expected answer.
    typedef struct {
        t_lcd_request req;
        int           n_typed;
        t_lcd_strobe  typed [2];
    } t_directed_row;

    localparam t_lcd_strobe NIL = '0;

    logic clk;
    logic rst_n;

    lcdnf_req_if    req_bus ();
    lcdnf_strobe_if strobe_bus ();

    char_lcd_nibble_framer_top #(
        .LINE_COLUMNS(LINE_COLUMNS)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus),
        .o_strobe(strobe_bus)
    );

    t_lcd_strobe pending_strobes [$];
    int          mismatch_count;
    int          beats_checked;
    int          requests_sent;
    int          cycle_count;
    int          op_hits [16];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Directed requests: field extremes, every operation, decimal with zeros in
    // each position, hex with and without a high digit, clear line with no
    // columns, a full line and counts that saturate, and unused op codes.
    t_directed_row directed_rows [N_DIRECTED] = '{
        '{'{lcdnf_pkg::OP_CMD, 8'h00, 1'b0, 6'd0, 8'd0}, 2,
          '{'{8'h0C, 8'h08, lcdnf_pkg::W_50US, 1'b0},
            '{8'h0C, 8'h08, lcdnf_pkg::W_50US, 1'b1}}},
        '{'{lcdnf_pkg::OP_CMD, 8'hFF, 1'b1, 6'd63, 8'd255}, 2,
          '{'{8'hFC, 8'hF8, lcdnf_pkg::W_50US, 1'b0},
            '{8'hFC, 8'hF8, lcdnf_pkg::W_50US, 1'b1}}},
        '{'{lcdnf_pkg::OP_CHAR, 8'h00, 1'b0, 6'd0, 8'd0}, 2,
          '{'{8'h0D, 8'h09, lcdnf_pkg::W_50US, 1'b0},
            '{8'h0D, 8'h09, lcdnf_pkg::W_50US, 1'b1}}},
        '{'{lcdnf_pkg::OP_CHAR, 8'hFF, 1'b0, 6'd0, 8'd0}, 2,
          '{'{8'hFD, 8'hF9, lcdnf_pkg::W_50US, 1'b0},
            '{8'hFD, 8'hF9, lcdnf_pkg::W_50US, 1'b1}}},
        '{'{lcdnf_pkg::OP_MOVE, 8'h00, 1'b0, 6'd0, 8'd0},      -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_MOVE, 8'h00, 1'b1, 6'd63, 8'd0},     -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_DEC, 8'd0, 1'b0, 6'd0, 8'd0},        -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_DEC, 8'd10, 1'b0, 6'd0, 8'd0},       -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_DEC, 8'd100, 1'b0, 6'd0, 8'd0},      -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_DEC, 8'd255, 1'b0, 6'd0, 8'd0},      -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_HEX, 8'h00, 1'b0, 6'd0, 8'd0},       -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_HEX, 8'h0F, 1'b0, 6'd0, 8'd0},       -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_HEX, 8'h10, 1'b0, 6'd0, 8'd0},       -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_HEX, 8'hFF, 1'b0, 6'd0, 8'd0},       -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_CLRLINE, 8'h00, 1'b0, 6'd0, 8'd0},   -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_CLRLINE, 8'h00, 1'b1, 6'd0, 8'd16},  -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_CLRLINE, 8'h00, 1'b0, 6'd0, 8'd17},  -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_CLRLINE, 8'h00, 1'b1, 6'd0, 8'd255}, -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_CLEAR, 8'h00, 1'b0, 6'd0, 8'd0}, 2,
          '{'{8'h0C, 8'h08, lcdnf_pkg::W_50US, 1'b0},
            '{8'h1C, 8'h18, lcdnf_pkg::W_2MS, 1'b1}}},
        '{'{lcdnf_pkg::OP_INIT, 8'h00, 1'b0, 6'd0, 8'd0},      -1, '{NIL, NIL}},
        '{'{lcdnf_pkg::OP_SHUTDOWN, 8'h00, 1'b0, 6'd0, 8'd0},  -1, '{NIL, NIL}},
        '{'{OP_UNUSED_LO, 8'hA5, 1'b1, 6'd21, 8'd3}, 0, '{NIL, NIL}},
        '{'{OP_UNUSED_HI, 8'hFF, 1'b1, 6'd63, 8'd255}, 0, '{NIL, NIL}}
    };

    initial begin
        clk = 1'b0;
        forever begin
            #1 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Strobe predictor. Each nibble goes out as one strobe: the byte with
    // the enable bit set, then without it. Backlight is always on and the
    // write-select bit is always clear.
    // ------------------------------------------------------------------
    function automatic void push_nibble(input logic [3:0] nib, input logic rs,
                                        input lcdnf_pkg::t_wait wait_class);
        t_lcd_strobe s;
        logic [7:0]  base;
        base         = {nib, 4'h0} | lcdnf_pkg::BIT_BL | (rs ? lcdnf_pkg::BIT_RS : 8'h00);
        s.high_byte  = base | lcdnf_pkg::BIT_EN;
        s.low_byte   = base;
        s.wait_after = wait_class;
        s.last       = 1'b0;
        pending_strobes.push_back(s);
    endfunction

    // A byte is two strobes, high nibble first; only the second carries the
    // requested wait, the first always waits the short interval.
    function automatic void push_byte(input logic [7:0] b, input logic rs,
                                      input lcdnf_pkg::t_wait wait_last);
        push_nibble(b[7:4], rs, lcdnf_pkg::W_50US);
        push_nibble(b[3:0], rs, wait_last);
    endfunction

    function automatic logic [7:0] hex_digit_ascii(input logic [3:0] d);
        return (d < 4'd10) ? CHAR_ZERO + 8'(d) : CHAR_A + 8'(d - 4'd10);
    endfunction

    function automatic void frame_request(input t_lcd_request r);
        int unsigned first_idx;
        int unsigned hundreds;
        int unsigned tens;
        int unsigned blanks;
        t_lcd_strobe tail;
        first_idx = pending_strobes.size();
        case (r.op)
            lcdnf_pkg::OP_CMD: begin
                push_byte(r.value, 1'b0, lcdnf_pkg::W_50US);
            end
            lcdnf_pkg::OP_CHAR: begin
                push_byte(r.value, 1'b1, lcdnf_pkg::W_50US);
            end
            lcdnf_pkg::OP_MOVE: begin
                // The column is added to the row base address; the sum stays within eight bits.
                push_byte((CMD_SET_ADDR | (r.row ? ROW1_BASE : 8'h00)) + {2'b00, r.col},
                          1'b0, lcdnf_pkg::W_50US);
            end
            lcdnf_pkg::OP_DEC: begin
                // Leading zeros go, but a zero in the middle stays.
                hundreds = r.value / 100;
                tens     = (r.value / 10) % 10;
                if (hundreds != 0) begin
                    push_byte(CHAR_ZERO + 8'(hundreds), 1'b1, lcdnf_pkg::W_50US);
                end
                if (hundreds != 0 || tens != 0) begin
                    push_byte(CHAR_ZERO + 8'(tens), 1'b1, lcdnf_pkg::W_50US);
                end
                push_byte(CHAR_ZERO + 8'(r.value % 10), 1'b1, lcdnf_pkg::W_50US);
            end
            lcdnf_pkg::OP_HEX: begin
                push_byte(CHAR_X, 1'b1, lcdnf_pkg::W_50US);
                if (r.value[7:4] != 4'h0) begin
                    push_byte(hex_digit_ascii(r.value[7:4]), 1'b1, lcdnf_pkg::W_50US);
                end
                push_byte(hex_digit_ascii(r.value[3:0]), 1'b1, lcdnf_pkg::W_50US);
            end
            lcdnf_pkg::OP_CLRLINE: begin
                push_byte(CMD_SET_ADDR | (r.row ? ROW1_BASE : 8'h00), 1'b0,
                          lcdnf_pkg::W_50US);
                blanks = (r.blank_cols > LINE_COLUMNS) ? LINE_COLUMNS : r.blank_cols;
                for (int k = 0; k < blanks; k++) begin
                    push_byte(CHAR_SPACE, 1'b1, lcdnf_pkg::W_50US);
                end
            end
            lcdnf_pkg::OP_CLEAR: begin
                push_byte(CMD_CLEAR, 1'b0, lcdnf_pkg::W_2MS);
            end
            lcdnf_pkg::OP_INIT: begin
                // Wake-up nibbles in 8-bit mode, then the switch to 4-bit mode,
                // then the set-up commands as whole bytes.
                push_nibble(4'h0, 1'b0, lcdnf_pkg::W_50MS);
                push_nibble(4'h3, 1'b0, lcdnf_pkg::W_5MS);
                push_nibble(4'h3, 1'b0, lcdnf_pkg::W_200US);
                push_nibble(4'h3, 1'b0, lcdnf_pkg::W_200US);
                push_nibble(4'h2, 1'b0, lcdnf_pkg::W_50US);
                push_byte(CMD_FUNC_4BIT_2L, 1'b0, lcdnf_pkg::W_50US);
                push_byte(CMD_DISPLAY_OFF, 1'b0, lcdnf_pkg::W_50US);
                push_byte(CMD_CLEAR, 1'b0, lcdnf_pkg::W_2MS);
                push_byte(CMD_ENTRY_INC, 1'b0, lcdnf_pkg::W_50US);
                push_byte(CMD_DISPLAY_ON, 1'b0, lcdnf_pkg::W_50US);
            end
            lcdnf_pkg::OP_SHUTDOWN: begin
                push_byte(CMD_CLEAR, 1'b0, lcdnf_pkg::W_2MS);
                push_byte(CMD_DISPLAY_OFF, 1'b0, lcdnf_pkg::W_50US);
            end
            default: begin
                // Unused codes send nothing at all.
            end
        endcase
        if (pending_strobes.size() > first_idx) begin
            tail      = pending_strobes[pending_strobes.size() - 1];
            tail.last = 1'b1;
            pending_strobes[pending_strobes.size() - 1] = tail;
        end
    endfunction

    function automatic t_lcd_request random_request();
        t_lcd_request r;
        // A few unused codes; otherwise the nine real operations evenly.
        if ($urandom_range(99) < 6) begin
            r.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        end else begin
            r.op = 4'($urandom_range(lcdnf_pkg::OP_SHUTDOWN, lcdnf_pkg::OP_CMD));
        end
        r.value = 8'($urandom);
        r.row   = 1'($urandom);
        r.col   = 6'($urandom);
        // Mostly short clear-line requests around the saturation point, now
        // and then any count at all so every bit of the field moves.
        if ($urandom_range(9) == 0) begin
            r.blank_cols = 8'($urandom);
        end else begin
            r.blank_cols = 8'($urandom_range(20));
        end
        return r;
    endfunction

    // Offer one request and return once it has been taken. Idle cycles come
    // first, so valid only drops when a gap is wanted.
    task automatic send_request(input t_lcd_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.op         <= r.op;
        req_bus.value      <= r.value;
        req_bus.row        <= r.row;
        req_bus.col        <= r.col;
        req_bus.blank_cols <= r.blank_cols;
        @(posedge clk);
        while (!req_bus.ready) begin
            @(posedge clk);
        end
        requests_sent++;
        op_hits[r.op]++;
    endtask

    // Hold back the sender until every expected strobe has come out, then
    // give the block time to show any beat it should not have.
    task automatic drain_strobes();
        req_bus.valid <= 1'b0;
        while (pending_strobes.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic compare_field(input string field, input int unsigned expected_val,
                                 input int unsigned actual_val);
        if (expected_val != actual_val) begin
            mismatch_count++;
            $display("%0t: strobe beat %0d, %s expected 0x%0h, got 0x%0h",
                     $time, beats_checked, field, expected_val, actual_val);
        end
    endtask

    // ------------------------------------------------------------------
    // Strobe side: check each accepted beat against the oldest expectation,
    // then choose whether to stall the next cycle.
    // ------------------------------------------------------------------
    initial begin
        t_lcd_strobe want;
        strobe_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && strobe_bus.valid && strobe_bus.ready) begin
                if (pending_strobes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected strobe beat, expected none, %s %02h/%02h w%0d l%0b",
                             $time, "got", strobe_bus.strobe_high_byte,
                             strobe_bus.strobe_low_byte, strobe_bus.wait_after,
                             strobe_bus.last);
                end else begin
                    want = pending_strobes.pop_front();
                    compare_field("strobe_high_byte", want.high_byte,
                                  strobe_bus.strobe_high_byte);
                    compare_field("strobe_low_byte", want.low_byte,
                                  strobe_bus.strobe_low_byte);
                    compare_field("wait_after", want.wait_after, strobe_bus.wait_after);
                    compare_field("last", want.last, strobe_bus.last);
                end
                beats_checked++;
            end
            if (!rst_n) begin
                strobe_bus.ready <= 1'b0;
            end else begin
                strobe_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: the limit is several times the slowest legal run, with every
    // request at its longest and every beat stalled by the busy receiver.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timed out after %0d cycles, %0d strobes still expected",
                 $time, cycle_count, pending_strobes.size());
        $display("** char_lcd_nibble_framer_top: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int ops_covered;
        int unused_covered;
        mismatch_count     = 0;
        beats_checked      = 0;
        requests_sent      = 0;
        ops_covered        = 0;
        unused_covered     = 0;
        foreach (op_hits[k]) op_hits[k] = 0;
        send_idle_pct      = 7;
        recv_idle_pct      = 76;
        rst_n              <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.op         <= lcdnf_pkg::OP_CMD;
        req_bus.value      <= 8'h00;
        req_bus.row        <= 1'b0;
        req_bus.col        <= 6'd0;
        req_bus.blank_cols <= 8'd0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, with a slow receiver so strobes queue up behind it.
        foreach (directed_rows[k]) begin
            send_request(directed_rows[k].req);
            if (directed_rows[k].n_typed < 0) begin
                frame_request(directed_rows[k].req);
            end else begin
                for (int s = 0; s < directed_rows[k].n_typed; s++) begin
                    pending_strobes.push_back(directed_rows[k].typed[s]);
                end
            end
        end

        // Random requests, first against a slow receiver ...
        repeat (RANDOM_PHASE_A) begin
            t_lcd_request r;
            r = random_request();
            send_request(r);
            frame_request(r);
        end
        drain_strobes();

        // ... then with a sparse sender and an eager receiver ...
        send_idle_pct = 76;
        recv_idle_pct = 7;
        repeat (RANDOM_PHASE_B) begin
            t_lcd_request r;
            r = random_request();
            send_request(r);
            frame_request(r);
        end
        drain_strobes();

        // ... and finally back to back on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PHASE_C) begin
            t_lcd_request r;
            r = random_request();
            send_request(r);
            frame_request(r);
        end
        drain_strobes();

        for (int k = 0; k < 16; k++) begin
            if (op_hits[k] != 0) begin
                if (k <= lcdnf_pkg::OP_SHUTDOWN) ops_covered++;
                else unused_covered++;
            end
        end
        $display("Run covered %0d requests (%0d from the directed table) and %0d strobe beats,",
                 requests_sent, N_DIRECTED, beats_checked);
        $display("touching %0d of 9 operations and %0d unused op codes; %0d mismatches.",
                 ops_covered, unused_covered, mismatch_count);
        if (mismatch_count == 0) begin
            $display("** char_lcd_nibble_framer_top: PASSED **");
        end else begin
            $display("** char_lcd_nibble_framer_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> files.f
sv/lcdnf_pkg.sv
sv/lcdnf_req_if.sv
sv/lcdnf_strobe_if.sv
sv/lcdnf_ctrl.sv
sv/lcdnf_dp.sv
sv/char_lcd_nibble_framer_top.sv
sv/lcdnf_checker.sv
dv/testbench.sv
